>>> src/gkc_pkg.sv
`default_nettype none

package gkc_pkg;

    localparam int GKC_MAX_SIZE = 31;

    localparam int SIZE_W  = 5;
    localparam int IDX_W   = 5;
    localparam int VAR_W   = 16;
    localparam int KIND_W  = 2;
    localparam int CFG_A_W = 2;
    localparam int COEF_W  = 32;

    localparam int OFS_W   = 7;
    localparam int D2_W    = 11;
    localparam int PROD_W  = 11;
    localparam int A16_W   = 32;
    localparam int FRAC_W  = 16;
    localparam int U_W     = 30;
    localparam int P_W     = 31;
    localparam int AMP_W   = 29;
    localparam int MAG_W   = 56;
    localparam int CUBE_W  = 48;
    localparam int KSH_W   = 6;

    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [28:0] INVPI_Q30 = 29'd341782638;
    localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
    localparam int          EXP_TERMS = 10;

    typedef enum logic [KIND_W-1:0] {
        KIND_GAUSS = 2'd0,
        KIND_DXDY  = 2'd1,
        KIND_LOG   = 2'd2
    } t_kind;

    typedef enum logic [CFG_A_W-1:0] {
        CFG_SIZE     = 2'd0,
        CFG_VARIANCE = 2'd1,
        CFG_KIND     = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic                     invalid;
        logic signed [PROD_W-1:0] prod;
        logic [D2_W-1:0]          d2;
        logic                     kbig;
        logic [KSH_W-1:0]         kshift;
    } t_meta;

    typedef struct packed {
        logic             invalid;
        logic             neg;
        logic             kbig;
        logic [KSH_W-1:0] kshift;
    } t_tail;

    // reciprocal multiplier for exact floor(x/d), x below 2^30
    function automatic logic [30:0] recip_mul(input int d);
        logic [30:0] m;
        case (d)
            1:       m = 31'd1073741824;
            2:       m = 31'd1073741824;
            3:       m = 31'd1431655766;
            4:       m = 31'd1073741824;
            5:       m = 31'd1717986919;
            6:       m = 31'd1431655766;
            7:       m = 31'd1227133514;
            8:       m = 31'd1073741824;
            9:       m = 31'd1908874354;
            10:      m = 31'd1717986919;
            default: m = 31'd1073741824;
        endcase
        return m;
    endfunction

    function automatic int recip_shift(input int d);
        int s;
        case (d)
            1:       s = 30;
            2:       s = 31;
            3:       s = 32;
            4:       s = 32;
            5:       s = 33;
            6:       s = 33;
            7:       s = 33;
            8:       s = 33;
            9:       s = 34;
            10:      s = 34;
            default: s = 30;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

>>> src/gaussian_kernel_coefficient.sv
// throughput: one beat per cycle while the output is not back-pressured;
// fully pipelined (two bit-per-stage dividers, 32 and 56 stages, and a
// 20-stage exp series set the depth)
// reset: all stage valid bits and the output valid clear; kernel_size 5,
// variance 1.0, gaussian kind
`default_nettype none

module gaussian_kernel_coefficient (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [gkc_pkg::CFG_A_W-1:0]      i_cfg_index,
    input  wire logic [gkc_pkg::VAR_W-1:0]        i_cfg_data,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [gkc_pkg::IDX_W-1:0]        i_row,
    input  wire logic [gkc_pkg::IDX_W-1:0]        i_col,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic signed [gkc_pkg::COEF_W-1:0]     o_coefficient,
    output logic                                  o_saturated,
    output logic                                  o_index_invalid
);

    localparam int NT = gkc_pkg::EXP_TERMS;

    logic adv;

    // configuration
    logic [gkc_pkg::SIZE_W-1:0] r_kernel_size;
    logic [gkc_pkg::VAR_W-1:0]  r_variance;
    logic [gkc_pkg::KIND_W-1:0] r_kernel_kind;
    logic [gkc_pkg::VAR_W-1:0]  v_eff;
    logic [2*gkc_pkg::VAR_W-1:0] r_vsq;
    logic [gkc_pkg::CUBE_W-1:0]  r_vcube;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_size <= gkc_pkg::SIZE_W'(5);
            r_variance    <= gkc_pkg::VAR_W'(256);
            r_kernel_kind <= gkc_pkg::KIND_GAUSS;
        end else if (i_cfg_valid) begin
            case (gkc_pkg::t_cfg_reg'(i_cfg_index))
                gkc_pkg::CFG_SIZE:     r_kernel_size <= i_cfg_data[gkc_pkg::SIZE_W-1:0];
                gkc_pkg::CFG_VARIANCE: r_variance    <= i_cfg_data;
                gkc_pkg::CFG_KIND:     r_kernel_kind <= i_cfg_data[gkc_pkg::KIND_W-1:0];
                default: ;
            endcase
        end
    end

    assign v_eff = (r_variance == '0) ? gkc_pkg::VAR_W'(1) : r_variance;

    always_ff @(posedge i_clk) begin
        r_vsq   <= v_eff * v_eff;
        r_vcube <= r_vsq * v_eff;
    end

    assign adv        = !o_out_valid || i_out_ready;
    assign o_in_ready = adv;

    // stage 0: centered offsets
    logic [gkc_pkg::SIZE_W-1:0]     n_eff;
    logic signed [7:0]              dx_full;
    logic signed [7:0]              dy_full;
    logic                           r_s0_vld;
    logic                           r_s0_inv;
    logic signed [gkc_pkg::OFS_W-1:0] r_s0_dx;
    logic signed [gkc_pkg::OFS_W-1:0] r_s0_dy;

    always_comb begin
        n_eff = ({3'b0, r_kernel_size} > 8'(gkc_pkg::GKC_MAX_SIZE))
              ? gkc_pkg::SIZE_W'(gkc_pkg::GKC_MAX_SIZE) : r_kernel_size;
        dx_full = $signed({2'b0, i_col, 1'b0}) - $signed({3'b0, n_eff}) + 8'sd1;
        dy_full = $signed({2'b0, i_row, 1'b0}) - $signed({3'b0, n_eff}) + 8'sd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (adv) begin
            r_s0_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s0_inv <= (i_row >= n_eff) || (i_col >= n_eff);
            r_s0_dx  <= dx_full[gkc_pkg::OFS_W-1:0];
            r_s0_dy  <= dy_full[gkc_pkg::OFS_W-1:0];
        end
    end

    // stage 1: squared radius and offset product
    logic signed [13:0]  sq_sum;
    logic signed [13:0]  xy;
    logic                r_s1_vld;
    gkc_pkg::t_meta      r_s1_meta;

    always_comb begin
        sq_sum = 14'(r_s0_dx * r_s0_dx) + 14'(r_s0_dy * r_s0_dy);
        xy     = 14'(r_s0_dx * r_s0_dy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (adv) begin
            r_s1_vld <= r_s0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_meta.invalid <= r_s0_inv;
            r_s1_meta.prod    <= xy[gkc_pkg::PROD_W-1:0];
            r_s1_meta.d2      <= sq_sum[gkc_pkg::D2_W-1:0];
            r_s1_meta.kbig    <= 1'b0;
            r_s1_meta.kshift  <= '0;
        end
    end

    // exponent a16 = d2 * 2^21 / v
    logic                         d1_vld;
    logic [gkc_pkg::A16_W-1:0]    d1_quo;
    logic [$bits(gkc_pkg::t_meta)-1:0] d1_side;
    gkc_pkg::t_meta               d1_meta;

    gkc_div #(
        .NUM_W  (gkc_pkg::A16_W),
        .DEN_W  (gkc_pkg::VAR_W),
        .SIDE_W ($bits(gkc_pkg::t_meta))
    ) u_div_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_s1_vld),
        .i_num   ({r_s1_meta.d2, 21'b0}),
        .i_den   (v_eff),
        .i_side  (r_s1_meta),
        .o_valid (d1_vld),
        .o_quo   (d1_quo),
        .o_side  (d1_side)
    );

    assign d1_meta = gkc_pkg::t_meta'(d1_side);

    // stage t: base-2 exponent split
    logic [63:0]                 t_full;
    logic [32:0]                 t_val;
    logic [16:0]                 k_int;
    gkc_pkg::t_meta              n_t_meta;
    logic                        r_t_vld;
    logic [gkc_pkg::FRAC_W-1:0]  r_t_f;
    gkc_pkg::t_meta              r_t_meta;

    always_comb begin
        t_full = 64'(d1_quo) * 64'(gkc_pkg::LOG2E_Q30);
        t_val  = t_full[62:30];
        k_int  = t_val[32:16];
        n_t_meta        = d1_meta;
        n_t_meta.kbig   = (k_int > 17'd62);
        n_t_meta.kshift = k_int[gkc_pkg::KSH_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_vld <= 1'b0;
        end else if (adv) begin
            r_t_vld <= d1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_t_f    <= t_val[gkc_pkg::FRAC_W-1:0];
            r_t_meta <= n_t_meta;
        end
    end

    // stage u: fraction back to natural base
    logic [45:0]              u_full;
    logic                     r_u_vld;
    logic [gkc_pkg::U_W-1:0]  r_u_u;
    gkc_pkg::t_meta           r_u_meta;

    assign u_full = 46'(r_t_f) * 46'(gkc_pkg::LN2_Q30);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_vld <= 1'b0;
        end else if (adv) begin
            r_u_vld <= r_t_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_u_u    <= u_full[45:16];
            r_u_meta <= r_t_meta;
        end
    end

    // exp(-u) horner series, two stages per term
    logic [NT-1:0]            r_ea_vld;
    logic [gkc_pkg::U_W-1:0]  r_ea_u    [NT];
    logic [gkc_pkg::U_W-1:0]  r_ea_x    [NT];
    gkc_pkg::t_meta           r_ea_meta [NT];
    logic [NT-1:0]            r_eb_vld;
    logic [gkc_pkg::U_W-1:0]  r_eb_u    [NT];
    logic [gkc_pkg::P_W-1:0]  r_eb_p    [NT];
    gkc_pkg::t_meta           r_eb_meta [NT];

    for (genvar i = 0; i < NT; i++) begin : g_term
        localparam int          DV  = NT - i;
        localparam logic [30:0] MUL = gkc_pkg::recip_mul(DV);
        localparam int          SH  = gkc_pkg::recip_shift(DV);

        logic                    a_vld;
        logic [gkc_pkg::U_W-1:0] a_u;
        logic [gkc_pkg::P_W-1:0] a_p;
        gkc_pkg::t_meta          a_meta;
        logic [60:0]             up_full;
        logic [60:0]             xm_full;
        logic [gkc_pkg::U_W-1:0] quot;

        if (i == 0) begin : g_first
            assign a_vld  = r_u_vld;
            assign a_u    = r_u_u;
            assign a_p    = gkc_pkg::ONE_Q30;
            assign a_meta = r_u_meta;
        end else begin : g_next
            assign a_vld  = r_eb_vld[i-1];
            assign a_u    = r_eb_u[i-1];
            assign a_p    = r_eb_p[i-1];
            assign a_meta = r_eb_meta[i-1];
        end

        always_comb begin
            up_full = 61'(a_u) * 61'(a_p);
            xm_full = 61'(r_ea_x[i]) * 61'(MUL);
            quot    = gkc_pkg::U_W'(xm_full >> SH);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ea_vld[i] <= 1'b0;
                r_eb_vld[i] <= 1'b0;
            end else if (adv) begin
                r_ea_vld[i] <= a_vld;
                r_eb_vld[i] <= r_ea_vld[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_ea_u[i]    <= a_u;
                r_ea_x[i]    <= up_full[59:30];
                r_ea_meta[i] <= a_meta;
                r_eb_u[i]    <= r_ea_u[i];
                r_eb_p[i]    <= gkc_pkg::ONE_Q30 - {1'b0, quot};
                r_eb_meta[i] <= r_ea_meta[i];
            end
        end
    end

    // stage a: scale by 1/pi
    logic [59:0]                amp_full;
    logic                       r_a_vld;
    logic [gkc_pkg::AMP_W-1:0]  r_a_amp;
    gkc_pkg::t_meta             r_a_meta;

    assign amp_full = 60'(r_eb_p[NT-1]) * 60'(gkc_pkg::INVPI_Q30);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (adv) begin
            r_a_vld <= r_eb_vld[NT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_amp  <= amp_full[58:30];
            r_a_meta <= r_eb_meta[NT-1];
        end
    end

    // stage m: numerator, sign and divisor by kind
    logic [gkc_pkg::VAR_W-1:0]  d2x32;
    logic                       dneg;
    logic [gkc_pkg::VAR_W-1:0]  adiff;
    logic                       pneg;
    logic [gkc_pkg::PROD_W-1:0] aprod;
    logic [gkc_pkg::VAR_W-1:0]  mul_in;
    logic [44:0]                pm;
    logic [gkc_pkg::MAG_W-1:0]  mag;
    logic                       mneg;
    logic                       r_m_vld;
    logic [gkc_pkg::MAG_W-1:0]  r_m_mag;
    logic [gkc_pkg::CUBE_W-1:0] r_m_den;
    gkc_pkg::t_tail             r_m_tail;

    always_comb begin
        d2x32  = {r_a_meta.d2, 5'b0};
        dneg   = (d2x32 < v_eff);
        adiff  = dneg ? (v_eff - d2x32) : (d2x32 - v_eff);
        pneg   = r_a_meta.prod[gkc_pkg::PROD_W-1];
        aprod  = pneg ? (gkc_pkg::PROD_W'(0) - r_a_meta.prod) : r_a_meta.prod;
        mul_in = (r_kernel_kind == gkc_pkg::KIND_DXDY)
               ? gkc_pkg::VAR_W'(aprod) : adiff;
        pm     = 45'(r_a_amp) * 45'(mul_in);
        case (gkc_pkg::t_kind'(r_kernel_kind))
            gkc_pkg::KIND_GAUSS: begin
                mag  = gkc_pkg::MAG_W'(r_a_amp) << 1;
                mneg = 1'b0;
            end
            gkc_pkg::KIND_DXDY: begin
                mag  = gkc_pkg::MAG_W'(pm) << 13;
                mneg = pneg;
            end
            gkc_pkg::KIND_LOG: begin
                mag  = gkc_pkg::MAG_W'(pm) << 10;
                mneg = dneg;
            end
            default: begin
                mag  = '0;
                mneg = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (adv) begin
            r_m_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m_mag         <= mag;
            r_m_den         <= (r_kernel_kind == gkc_pkg::KIND_GAUSS)
                             ? gkc_pkg::CUBE_W'(v_eff) : r_vcube;
            r_m_tail.invalid <= r_a_meta.invalid;
            r_m_tail.neg     <= mneg;
            r_m_tail.kbig    <= r_a_meta.kbig;
            r_m_tail.kshift  <= r_a_meta.kshift;
        end
    end

    // magnitude quotient
    logic                              d2_vld;
    logic [gkc_pkg::MAG_W-1:0]         d2_quo;
    logic [$bits(gkc_pkg::t_tail)-1:0] d2_side;
    gkc_pkg::t_tail                    d2_tail;

    gkc_div #(
        .NUM_W  (gkc_pkg::MAG_W),
        .DEN_W  (gkc_pkg::CUBE_W),
        .SIDE_W ($bits(gkc_pkg::t_tail))
    ) u_div_mag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_m_vld),
        .i_num   (r_m_mag),
        .i_den   (r_m_den),
        .i_side  (r_m_tail),
        .o_valid (d2_vld),
        .o_quo   (d2_quo),
        .o_side  (d2_side)
    );

    assign d2_tail = gkc_pkg::t_tail'(d2_side);

    // stage f: power-of-two scale
    logic                      r_f_vld;
    logic [gkc_pkg::MAG_W-1:0] r_f_r;
    gkc_pkg::t_tail            r_f_tail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (adv) begin
            r_f_vld <= d2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_f_r    <= d2_tail.kbig ? '0 : (d2_quo >> d2_tail.kshift);
            r_f_tail <= d2_tail;
        end
    end

    // output register: saturate and sign
    logic [gkc_pkg::COEF_W-1:0] n_coef;
    logic                       n_sat;
    logic                       r_out_valid;
    logic [gkc_pkg::COEF_W-1:0] r_out_coef;
    logic                       r_out_sat;
    logic                       r_out_inv;

    always_comb begin
        n_coef = '0;
        n_sat  = 1'b0;
        if (r_f_tail.invalid) begin
            n_coef = '0;
            n_sat  = 1'b0;
        end else if (!r_f_tail.neg) begin
            if (r_f_r > gkc_pkg::MAG_W'(32'h7FFF_FFFF)) begin
                n_coef = 32'h7FFF_FFFF;
                n_sat  = 1'b1;
            end else begin
                n_coef = r_f_r[gkc_pkg::COEF_W-1:0];
            end
        end else begin
            if (r_f_r > gkc_pkg::MAG_W'(32'h8000_0000)) begin
                n_coef = 32'h8000_0000;
                n_sat  = 1'b1;
            end else begin
                n_coef = 32'd0 - r_f_r[gkc_pkg::COEF_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_coef <= n_coef;
            r_out_sat  <= n_sat;
            r_out_inv  <= r_f_tail.invalid;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_coefficient   = $signed(r_out_coef);
    assign o_saturated     = r_out_sat;
    assign o_index_invalid = r_out_inv;

endmodule

`default_nettype wire

>>> src/gkc_div.sv
`default_nettype none

module gkc_div #(
    parameter int NUM_W  = 32,
    parameter int DEN_W  = 16,
    parameter int SIDE_W = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [DEN_W-1:0]  i_den,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [NUM_W-1:0]       o_quo,
    output logic [SIDE_W-1:0]      o_side
);

    // one quotient bit per stage, remainder and dividend/quotient shift word
    logic [DEN_W-1:0]  r_rem  [NUM_W];
    logic [NUM_W-1:0]  r_nq   [NUM_W];
    logic [SIDE_W-1:0] r_side [NUM_W];
    logic [NUM_W-1:0]  r_vld;

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic [DEN_W-1:0]  rem_in;
        logic [NUM_W-1:0]  nq_in;
        logic [SIDE_W-1:0] side_in;
        logic              vld_in;
        logic [DEN_W:0]    trial;
        logic [DEN_W:0]    diff;
        logic              ge;
        logic [DEN_W-1:0]  n_rem;
        logic [NUM_W-1:0]  n_nq;

        if (s == 0) begin : g_first
            assign rem_in  = '0;
            assign nq_in   = i_num;
            assign side_in = i_side;
            assign vld_in  = i_valid;
        end else begin : g_next
            assign rem_in  = r_rem[s-1];
            assign nq_in   = r_nq[s-1];
            assign side_in = r_side[s-1];
            assign vld_in  = r_vld[s-1];
        end

        always_comb begin
            trial = {rem_in, nq_in[NUM_W-1]};
            diff  = trial - {1'b0, i_den};
            ge    = (trial >= {1'b0, i_den});
            n_rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            n_nq  = {nq_in[NUM_W-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_rem;
                r_nq[s]   <= n_nq;
                r_side[s] <= side_in;
            end
        end
    end

    assign o_valid = r_vld[NUM_W-1];
    assign o_quo   = r_nq[NUM_W-1];
    assign o_side  = r_side[NUM_W-1];

endmodule

`default_nettype wire

>>> verif/tb_gaussian_kernel_coefficient.sv
`default_nettype none

module tb_gaussian_kernel_coefficient;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [gkc_pkg::CFG_A_W-1:0] CFG_UNUSED  = 2'd3;
    localparam logic [gkc_pkg::KIND_W-1:0]  KIND_UNUSED = 2'd3;
    localparam int                          LATENCY     = 116;
    localparam int                          STALL_LIMIT = 4000;

    typedef struct packed {
        logic signed [gkc_pkg::COEF_W-1:0] coef;
        logic                              sat;
        logic                              inv;
    } t_coef_beat;

    typedef struct {
        logic [gkc_pkg::IDX_W-1:0] row;
        logic [gkc_pkg::IDX_W-1:0] col;
        bit                        typed;
        t_coef_beat                val;
    } t_stim_row;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [gkc_pkg::CFG_A_W-1:0]       i_cfg_index = '0;
    logic [gkc_pkg::VAR_W-1:0]         i_cfg_data = '0;
    logic                              i_in_valid = 1'b0;
    logic                              o_in_ready;
    logic [gkc_pkg::IDX_W-1:0]         i_row = '0;
    logic [gkc_pkg::IDX_W-1:0]         i_col = '0;
    logic                              o_out_valid;
    logic                              i_out_ready = 1'b0;
    logic signed [gkc_pkg::COEF_W-1:0] o_coefficient;
    logic                              o_saturated;
    logic                              o_index_invalid;

    gaussian_kernel_coefficient dut (.*);

    // shadow registers
    logic [gkc_pkg::SIZE_W-1:0] size_q = gkc_pkg::SIZE_W'(5);
    logic [gkc_pkg::VAR_W-1:0]  var_q  = gkc_pkg::VAR_W'(256);
    logic [gkc_pkg::KIND_W-1:0] kind_q = gkc_pkg::KIND_GAUSS;

    t_coef_beat pending_coefs[$];
    t_coef_beat typed_val;
    bit         typed_next = 0;
    int         errors = 0;
    int         quiet_cycles = 0;
    bit         calm = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_coef_beat coef_of(logic [gkc_pkg::IDX_W-1:0] row,
                                           logic [gkc_pkg::IDX_W-1:0] col);
        t_coef_beat res;
        longint unsigned n, v, d2, a16, t, k, f, u, p, amp, mag, q, r;
        longint signed dx, dy, prod, diff;
        bit neg;
        res = '0;
        neg = 0;
        n = (size_q > gkc_pkg::GKC_MAX_SIZE) ? gkc_pkg::GKC_MAX_SIZE : size_q;
        if (row >= n || col >= n) begin
            res.inv = 1'b1;
            return res;
        end
        if (kind_q == KIND_UNUSED) return res;
        v = (var_q == 0) ? 1 : var_q;
        dx = 2 * longint'(col) - (longint'(n) - 1);
        dy = 2 * longint'(row) - (longint'(n) - 1);
        d2 = longint'(dx * dx + dy * dy);
        a16 = (d2 << 21) / v;
        t = (a16 * longint'(gkc_pkg::LOG2E_Q30)) >> 30;
        k = t >> 16;
        f = t & 64'hFFFF;
        u = (f * longint'(gkc_pkg::LN2_Q30)) >> 16;
        p = longint'(gkc_pkg::ONE_Q30);
        for (int d = gkc_pkg::EXP_TERMS; d >= 1; d--) begin
            p = longint'(gkc_pkg::ONE_Q30) - (((u * p) >> 30) / d);
        end
        amp = (p * longint'(gkc_pkg::INVPI_Q30)) >> 30;
        if (kind_q == gkc_pkg::KIND_GAUSS) begin
            mag = 2 * amp;
            q = v;
        end else if (kind_q == gkc_pkg::KIND_DXDY) begin
            prod = dx * dy;
            neg = prod < 0;
            mag = 2 * amp * longint'(neg ? -prod : prod) * 4096;
            q = v * v * v;
        end else begin
            diff = 32 * longint'(d2) - longint'(v);
            neg = diff < 0;
            mag = 2 * amp * longint'(neg ? -diff : diff) * 512;
            q = v * v * v;
        end
        r = mag / q;
        r = (k >= 63) ? 0 : (r >> k);
        if (!neg) begin
            if (r > 64'h7FFF_FFFF) begin
                r = 64'h7FFF_FFFF;
                res.sat = 1'b1;
            end
            res.coef = r[31:0];
        end else begin
            if (r > 64'h8000_0000) begin
                r = 64'h8000_0000;
                res.sat = 1'b1;
            end
            res.coef = -r[31:0];
        end
        return res;
    endfunction

    // watchdog, prediction and checking
    always @(posedge i_clk) begin
        t_coef_beat want;
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            pending_coefs.push_back(typed_next ? typed_val : coef_of(i_row, i_col));
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_coefs.size() == 0) begin
                $display("%0t: unexpected beat coef %h", $realtime, o_coefficient);
                errors++;
            end else begin
                want = pending_coefs.pop_front();
                if (o_coefficient !== want.coef) begin
                    $display("%0t: coefficient exp %h act %h", $realtime, want.coef,
                             o_coefficient);
                    errors++;
                end
                if (o_saturated !== want.sat) begin
                    $display("%0t: saturated exp %b act %b", $realtime, want.sat,
                             o_saturated);
                    errors++;
                end
                if (o_index_invalid !== want.inv) begin
                    $display("%0t: index_invalid exp %b act %b", $realtime, want.inv,
                             o_index_invalid);
                    errors++;
                end
            end
        end
    end

    // result side back-pressure
    initial begin
        int stall;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic cfg_write(logic [gkc_pkg::CFG_A_W-1:0] idx,
                             logic [gkc_pkg::VAR_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            gkc_pkg::CFG_SIZE:     size_q = data[gkc_pkg::SIZE_W-1:0];
            gkc_pkg::CFG_VARIANCE: var_q  = data;
            gkc_pkg::CFG_KIND:     kind_q = data[gkc_pkg::KIND_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_index(logic [gkc_pkg::IDX_W-1:0] row,
                              logic [gkc_pkg::IDX_W-1:0] col);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_row <= row;
        i_col <= col;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        wait (pending_coefs.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    initial begin
        t_stim_row dir_rows [10];
        logic [gkc_pkg::VAR_W-1:0] var_pick;
        int n;
        dir_rows = '{
            '{5'd2, 5'd2, 1, '{32'sd2670176, 1'b0, 1'b0}},
            '{5'd5, 5'd0, 1, '{32'sd0, 1'b0, 1'b1}},
            '{5'd0, 5'd31, 1, '{32'sd0, 1'b0, 1'b1}},
            '{5'd31, 5'd31, 1, '{32'sd0, 1'b0, 1'b1}},
            '{5'd0, 5'd0, 0, '0},
            '{5'd4, 5'd4, 0, '0},
            '{5'd0, 5'd4, 0, '0},
            '{5'd4, 5'd0, 0, '0},
            '{5'd1, 5'd3, 0, '0},
            '{5'd4, 5'd5, 0, '0}
        };
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            typed_val  <= dir_rows[i].val;
            typed_next <= dir_rows[i].typed;
            send_index(dir_rows[i].row, dir_rows[i].col);
        end
        typed_next <= 1'b0;
        drain();

        for (int ph = 0; ph < 14; ph++) begin
            calm = (ph % 5 == 3);
            case (ph)
                0: var_pick = 16'd1;
                1: var_pick = 16'd0;
                2: var_pick = 16'hFFFF;
                3: var_pick = 16'd256;
                default: var_pick = ($urandom_range(0, 3) == 0)
                         ? gkc_pkg::VAR_W'($urandom_range(1, 64))
                         : gkc_pkg::VAR_W'($urandom);
            endcase
            case (ph)
                0: cfg_write(gkc_pkg::CFG_SIZE, 16'd31);
                1: cfg_write(gkc_pkg::CFG_SIZE, 16'd1);
                2: cfg_write(gkc_pkg::CFG_SIZE, 16'd0);
                3: cfg_write(gkc_pkg::CFG_SIZE, 16'hFFE6);
                default: cfg_write(gkc_pkg::CFG_SIZE, gkc_pkg::VAR_W'($urandom));
            endcase
            cfg_write(gkc_pkg::CFG_VARIANCE, var_pick);
            cfg_write(gkc_pkg::CFG_KIND, (ph < 4) ? gkc_pkg::VAR_W'(ph)
                                                  : gkc_pkg::VAR_W'($urandom_range(0, 2)));
            if (ph % 4 == 1) begin
                cfg_write(CFG_UNUSED, gkc_pkg::VAR_W'($urandom));
            end
            n = (size_q == 0) ? 1 : int'(size_q);
            repeat (70) begin
                if ($urandom_range(0, 7) == 0) begin
                    send_index(gkc_pkg::IDX_W'($urandom), gkc_pkg::IDX_W'($urandom));
                end else begin
                    send_index(gkc_pkg::IDX_W'($urandom_range(0, n - 1)),
                               gkc_pkg::IDX_W'($urandom_range(0, n - 1)));
                end
            end
            drain();
        end

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
